// File: src/rsdd_pkg.sv
`timescale 1ns / 1ps

package rsdd_pkg;

    // field widths
    localparam int BYTE_W    = 8;
    localparam int DIST_W    = 18;
    localparam int STEP_W    = 11;
    localparam int CHAR_W    = 6;
    localparam int PARTIAL_W = 12;
    localparam int PHASE_W   = 2;

    // stream constants
    localparam logic [BYTE_W-1:0] LF_CHAR   = 8'h0a;
    localparam logic [CHAR_W-1:0] CHAR_BIAS = 6'h30;

    // reset value of header_skip and default step limit
    localparam logic [BYTE_W-1:0] HEADER_SKIP_RST = 8'd23;
    localparam int                MAX_STEPS_DEF   = 1080;

    // result queue depth
    localparam int FIFO_DEPTH = 3;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // triple assembler phases
    typedef enum logic [PHASE_W-1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_THIRD  = 2'd2
    } t_phase;

    // one result request
    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [STEP_W-1:0] step_index;
        logic              scan_end;
        logic              overflow;
    } t_result;

endpackage

// File: src/rsdd_core.sv
`timescale 1ns / 1ps

module rsdd_core
    import rsdd_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic [BYTE_W-1:0] i_header_skip,
    output logic              o_push,
    output t_result           o_result
);

    localparam logic [STEP_W-1:0] STEP_LIMIT = STEP_W'(MAX_STEPS);

    logic [BYTE_W-1:0]    r_skip_left, n_skip_left;
    logic [BYTE_W-1:0]    r_pending, n_pending;
    logic                 r_pending_valid, n_pending_valid;
    logic                 r_lf_run, n_lf_run;
    t_phase               r_phase, n_phase;
    logic [PARTIAL_W-1:0] r_partial, n_partial;
    logic [STEP_W-1:0]    r_step_count, n_step_count;
    logic                 r_too_many, n_too_many;

    logic [CHAR_W-1:0]    char_val;

    // six-bit character value of the held byte
    assign char_val = r_pending[CHAR_W-1:0] - CHAR_BIAS;

    // next state and result for one byte
    always_comb begin
        n_skip_left     = r_skip_left;
        n_pending       = r_pending;
        n_pending_valid = r_pending_valid;
        n_lf_run        = r_lf_run;
        n_phase         = r_phase;
        n_partial       = r_partial;
        n_step_count    = r_step_count;
        n_too_many      = r_too_many;
        o_push          = 1'b0;
        o_result        = '0;

        if (i_valid) begin
            if (r_skip_left != '0) begin
                // header bytes only count down
                n_skip_left = r_skip_left - 1'b1;
            end else if (i_byte == LF_CHAR) begin
                // held byte was the checksum
                n_pending_valid = 1'b0;
                if (r_lf_run) begin
                    // second line feed: end marker and rearm
                    o_push              = 1'b1;
                    o_result.step_index = r_step_count;
                    o_result.scan_end   = 1'b1;
                    o_result.overflow   = r_too_many;
                    n_skip_left         = i_header_skip;
                    n_pending           = '0;
                    n_lf_run            = 1'b0;
                    n_phase             = PH_FIRST;
                    n_partial           = '0;
                    n_step_count        = '0;
                    n_too_many          = 1'b0;
                end else begin
                    n_lf_run = 1'b1;
                end
            end else begin
                n_lf_run        = 1'b0;
                n_pending       = i_byte;
                n_pending_valid = 1'b1;
                // held byte is data: feed the triple assembler
                if (r_pending_valid) begin
                    case (r_phase)
                        PH_FIRST: begin
                            n_partial = {{(PARTIAL_W-CHAR_W){1'b0}}, char_val};
                            n_phase   = PH_SECOND;
                        end
                        PH_SECOND: begin
                            n_partial = {r_partial[CHAR_W-1:0], char_val};
                            n_phase   = PH_THIRD;
                        end
                        default: begin
                            n_phase   = PH_FIRST;
                            n_partial = '0;
                            if (r_step_count < STEP_LIMIT) begin
                                o_push              = 1'b1;
                                o_result.distance   = {r_partial, char_val};
                                o_result.step_index = r_step_count;
                                n_step_count        = r_step_count + 1'b1;
                            end else begin
                                n_too_many = 1'b1;
                            end
                        end
                    endcase
                end
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_left     <= HEADER_SKIP_RST;
            r_pending       <= '0;
            r_pending_valid <= 1'b0;
            r_lf_run        <= 1'b0;
            r_phase         <= PH_FIRST;
            r_partial       <= '0;
            r_step_count    <= '0;
            r_too_many      <= 1'b0;
        end else begin
            r_skip_left     <= n_skip_left;
            r_pending       <= n_pending;
            r_pending_valid <= n_pending_valid;
            r_lf_run        <= n_lf_run;
            r_phase         <= n_phase;
            r_partial       <= n_partial;
            r_step_count    <= n_step_count;
            r_too_many      <= n_too_many;
        end
    end

endmodule

// File: src/rsdd_fifo.sv
`timescale 1ns / 1ps

module rsdd_fifo
    import rsdd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  t_result               i_data,
    input  logic                  i_pop,
    output logic                  o_valid,
    output t_result               o_data,
    output logic [FIFO_CNT_W-1:0] o_count
);

    localparam logic [FIFO_PTR_W-1:0] LAST_PTR = FIFO_PTR_W'(FIFO_DEPTH - 1);

    t_result               r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic                  pop_ok;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;
    assign pop_ok  = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, pop_ok})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: src/range_scan_deframe_decode_top.sv
`timescale 1ns / 1ps

// Range scan reply deframer and three-character distance decoder.
// Input channel (i_in_valid / o_in_ready / i_rx_byte) takes one reply byte
// per request. Output channel (o_out_valid / i_out_ready) gives one result
// request: o_distance with o_step_index, or a scan end marker (o_scan_end
// high, o_distance zero, o_step_index the distance count, o_overflow set if
// more than MAX_STEPS distances arrived). A byte causes zero or one result.
// Configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes
// header_skip; it is always ready and takes effect at the next scan rearm.
// A taken byte is registered in the input register, its result in the queue.
// Throughput: one byte per cycle while o_in_ready is high, set by the input
// register, combinational decode logic and a three-entry result queue.
// When the receiver stalls, bytes keep being taken until the queue plus the
// byte in the input register fill three places; o_in_ready then drops.
// Synchronous reset: header_skip returns to 23, the scan is rearmed, the
// input register and result queue are emptied.

module range_scan_deframe_decode_top
    import rsdd_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [BYTE_W-1:0] i_rx_byte,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [DIST_W-1:0] o_distance,
    output logic [STEP_W-1:0] o_step_index,
    output logic              o_scan_end,
    output logic              o_overflow,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [BYTE_W-1:0] i_cfg_data
);

    logic [BYTE_W-1:0]     r_header_skip;
    logic                  r_in_valid;
    logic [BYTE_W-1:0]     r_in_byte;
    logic                  in_take;
    logic                  core_push;
    t_result               core_result;
    t_result               out_result;
    logic [FIFO_CNT_W-1:0] fifo_count;
    logic [FIFO_CNT_W:0]   reserved;

    // configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_skip <= HEADER_SKIP_RST;
        end else if (i_cfg_valid) begin
            r_header_skip <= i_cfg_data;
        end
    end

    // queue places held by stored results and the byte in flight
    assign reserved   = {1'b0, fifo_count} + {{FIFO_CNT_W{1'b0}}, r_in_valid};
    assign o_in_ready = (reserved < (FIFO_CNT_W+1)'(FIFO_DEPTH));
    assign in_take    = i_in_valid && o_in_ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // deframe and decode
    rsdd_core #(
        .MAX_STEPS (MAX_STEPS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (r_in_valid),
        .i_byte        (r_in_byte),
        .i_header_skip (r_header_skip),
        .o_push        (core_push),
        .o_result      (core_result)
    );

    // result queue
    rsdd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (core_push),
        .i_data  (core_result),
        .i_pop   (i_out_ready),
        .o_valid (o_out_valid),
        .o_data  (out_result),
        .o_count (fifo_count)
    );

    assign o_distance   = out_result.distance;
    assign o_step_index = out_result.step_index;
    assign o_scan_end   = out_result.scan_end;
    assign o_overflow   = out_result.overflow;

    // checks

    // queue never oversubscribed by results and the byte in flight
    a_no_oversubscribe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        reserved <= (FIFO_CNT_W+1)'(FIFO_DEPTH))
        else $error("result queue oversubscribed");

    // a push never lands on a full queue
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_push |-> (fifo_count < FIFO_CNT_W'(FIFO_DEPTH)))
        else $error("push into full result queue");

    // end marker carries no distance
    a_marker_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_scan_end) |-> (o_distance == '0))
        else $error("scan end marker with non-zero distance");

    // overflow only flagged in the end marker
    a_overflow_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_scan_end) |-> !o_overflow)
        else $error("overflow on a distance result");

endmodule
